FILE: rtl/qni_pkg.sv
// Shared constants, types and helper functions of the quadtree node index block.
// Has no dependencies. Every other file in rtl uses it by scoped names.
`default_nettype none

package qni_pkg;

	localparam int LEVELS      = 5;
	localparam int COORD_WIDTH = 24;
	localparam int NODE_W      = 11;
	localparam int LEVEL_W     = 3;
	localparam int REG_IDX_W   = 2;
	localparam int LANES       = 4;

	localparam int RST_ORIGIN_X     = -216000;
	localparam int RST_ORIGIN_Z     = -216000;
	localparam int RST_FIELD_LENGTH = 432000;
	localparam int RST_CELL_LENGTH  = 13500;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ORIGIN_X,
		REG_ORIGIN_Z,
		REG_FIELD_LENGTH,
		REG_CELL_LENGTH
	} reg_index_t;

	// Base offset of a tree level in the linear layout: 1 + 4 + ... + 4^(lvl-1).
	function automatic longint unsigned level_base(input int lvl);
		longint unsigned b;
		b = 0;
		for (int i = 0; i < lvl; i++) begin
			b = (b << 2) | 64'd1;
		end
		return b;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/qni_offset.sv
// First pipeline stage: subtracts the field origin from each corner coordinate
// and clamps the offset to the field. Uses qni_pkg.
`default_nettype none

module qni_offset #(
	parameter int COORD_WIDTH = qni_pkg::COORD_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_in,
	input  logic signed [COORD_WIDTH-1:0] coord [qni_pkg::LANES],
	input  logic signed [COORD_WIDTH-1:0] origin_x,
	input  logic signed [COORD_WIDTH-1:0] origin_z,
	input  logic        [COORD_WIDTH-2:0] clamp_hi,
	output logic                          valid_s1,
	output logic        [COORD_WIDTH-2:0] pos_s1 [qni_pkg::LANES]
);

	logic [COORD_WIDTH-2:0] pos_d [qni_pkg::LANES];

	for (genvar l = 0; l < qni_pkg::LANES; l++) begin : g_lane
		logic signed [COORD_WIDTH-1:0] org;
		logic signed [COORD_WIDTH:0]   diff;

		assign org  = (l % 2 == 0) ? origin_x : origin_z;
		assign diff = {coord[l][COORD_WIDTH-1], coord[l]} - {org[COORD_WIDTH-1], org};

		always_comb begin
			if (diff[COORD_WIDTH]) begin
				pos_d[l] = '0;
			end else if (diff[COORD_WIDTH-1:0] > {1'b0, clamp_hi}) begin
				pos_d[l] = clamp_hi;
			end else begin
				pos_d[l] = diff[COORD_WIDTH-2:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		pos_s1 <= pos_d;
	end

endmodule

`default_nettype wire

FILE: rtl/qni_div.sv
// Pipelined restoring divider that turns clamped offsets into saturated cell numbers.
// One stage checks saturation, then one stage per quotient bit. Uses qni_pkg.
`default_nettype none

module qni_div #(
	parameter int COORD_WIDTH = qni_pkg::COORD_WIDTH,
	parameter int LEVELS      = qni_pkg::LEVELS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   valid_in,
	input  logic [COORD_WIDTH-2:0] num [qni_pkg::LANES],
	input  logic [COORD_WIDTH-2:0] den,
	output logic                   valid_out,
	output logic [LEVELS-1:0]      quo [qni_pkg::LANES]
);

	localparam int NW = COORD_WIDTH - 1;
	localparam int RW = NW + LEVELS;

	logic [LEVELS:0]              vld_s;
	logic [LEVELS:0]              vld_d;
	logic [NW-1:0]                rem_s [LEVELS+1][qni_pkg::LANES];
	logic [NW-1:0]                rem_d [LEVELS+1][qni_pkg::LANES];
	logic [LEVELS-1:0]            quo_s [LEVELS+1][qni_pkg::LANES];
	logic [LEVELS-1:0]            quo_d [LEVELS+1][qni_pkg::LANES];
	logic [qni_pkg::LANES-1:0]    sat_s [LEVELS+1];
	logic [qni_pkg::LANES-1:0]    sat_d [LEVELS+1];

	always_comb begin
		logic [RW-1:0] dsh;
		logic          ge;
		dsh = '0;
		ge  = 1'b0;
		vld_d = {vld_s[LEVELS-1:0], valid_in};
		for (int l = 0; l < qni_pkg::LANES; l++) begin
			rem_d[0][l]    = num[l];
			quo_d[0][l]    = '0;
			sat_d[0][l]    = {{LEVELS{1'b0}}, num[l]} >= {den, {LEVELS{1'b0}}};
		end
		for (int s = 1; s <= LEVELS; s++) begin
			sat_d[s] = sat_s[s-1];
			for (int l = 0; l < qni_pkg::LANES; l++) begin
				dsh = RW'(den) << (LEVELS - s);
				ge  = RW'(rem_s[s-1][l]) >= dsh;
				rem_d[s][l] = ge ? rem_s[s-1][l] - dsh[NW-1:0] : rem_s[s-1][l];
				quo_d[s][l] = quo_s[s-1][l];
				quo_d[s][l][LEVELS-s] = ge;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		rem_s <= rem_d;
		quo_s <= quo_d;
		sat_s <= sat_d;
	end

	assign valid_out = vld_s[LEVELS];

	for (genvar l = 0; l < qni_pkg::LANES; l++) begin : g_out
		assign quo[l] = sat_s[LEVELS][l] ? {LEVELS{1'b1}} : quo_s[LEVELS][l];
	end

endmodule

`default_nettype wire

FILE: rtl/qni_encode.sv
// Last two pipeline stages: Morton interleave, level search on the code difference,
// then shift to the level and add the level base offset. Uses qni_pkg.
`default_nettype none

module qni_encode #(
	parameter int LEVELS = qni_pkg::LEVELS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid_in,
	input  logic [LEVELS-1:0]           cell_no [qni_pkg::LANES],
	output logic                        done,
	output logic [qni_pkg::NODE_W-1:0]  node_index,
	output logic [qni_pkg::LEVEL_W-1:0] tree_level
);

	localparam int CW   = 2 * LEVELS;
	localparam int LW   = $clog2(LEVELS + 1);
	localparam int SUMW = (CW + 1 > qni_pkg::NODE_W) ? CW + 1 : qni_pkg::NODE_W;
	localparam int LVW  = (LW > qni_pkg::LEVEL_W) ? LW : qni_pkg::LEVEL_W;

	logic [CW-1:0]   code1;
	logic [CW-1:0]   code2;
	logic [CW-1:0]   diff;
	logic [LW-1:0]   lvl_d;
	logic [SUMW-1:0] base_tab [LEVELS+1];

	logic            vld_s1;
	logic [CW-1:0]   code1_s1;
	logic [LW-1:0]   lvl_s1;

	logic [LW:0]     shamt;
	logic [SUMW-1:0] sum;
	logic [LVW-1:0]  lvl_ext;

	logic                        vld_s2;
	logic [qni_pkg::NODE_W-1:0]  node_s2;
	logic [qni_pkg::LEVEL_W-1:0] level_s2;

	for (genvar g = 0; g <= LEVELS; g++) begin : g_base
		assign base_tab[g] = SUMW'(qni_pkg::level_base(g));
	end

	for (genvar i = 0; i < LEVELS; i++) begin : g_interleave
		assign code1[2*i]   = cell_no[0][i];
		assign code1[2*i+1] = cell_no[1][i];
		assign code2[2*i]   = cell_no[2][i];
		assign code2[2*i+1] = cell_no[3][i];
	end

	assign diff = code1 ^ code2;

	always_comb begin
		lvl_d = LW'(LEVELS);
		for (int i = 0; i < LEVELS; i++) begin
			if (diff[2*i +: 2] != 2'b00) begin
				lvl_d = LW'(LEVELS - 1 - i);
			end
		end
	end

	assign shamt   = {LW'(LEVELS) - lvl_s1, 1'b0};
	assign sum     = base_tab[lvl_s1] + (SUMW'(code1_s1) >> shamt);
	assign lvl_ext = LVW'(lvl_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= valid_in;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		code1_s1 <= code1;
		lvl_s1   <= lvl_d;
		node_s2  <= sum[qni_pkg::NODE_W-1:0];
		level_s2 <= lvl_ext[qni_pkg::LEVEL_W-1:0];
	end

	assign done       = vld_s2;
	assign node_index = node_s2;
	assign tree_level = level_s2;

endmodule

`default_nettype wire

FILE: rtl/quadtree_node_index.sv
// Quadtree node index: maps a bounding box to its node in a linear quadtree.
// The pipeline from start to done has one clamp stage,
// LEVELS + 1 divider stages and two encode stages.
// Throughput is one box per cycle; busy stays low and the receiver cannot stall.
// Reset clears all valid bits and loads the configuration registers with their defaults.
`default_nettype none

module quadtree_node_index #(
	parameter int LEVELS      = qni_pkg::LEVELS,
	parameter int COORD_WIDTH = qni_pkg::COORD_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [COORD_WIDTH-1:0]   min_x,
	input  logic signed [COORD_WIDTH-1:0]   min_z,
	input  logic signed [COORD_WIDTH-1:0]   max_x,
	input  logic signed [COORD_WIDTH-1:0]   max_z,
	input  logic                            wr_en,
	input  logic [qni_pkg::REG_IDX_W-1:0]   wr_index,
	input  logic [COORD_WIDTH-1:0]          wr_data,
	output logic                            done,
	output logic [qni_pkg::NODE_W-1:0]      node_index,
	output logic [qni_pkg::LEVEL_W-1:0]     tree_level
);

	logic signed [COORD_WIDTH-1:0] origin_x_q;
	logic signed [COORD_WIDTH-1:0] origin_z_q;
	logic        [COORD_WIDTH-2:0] clamp_hi_q;
	logic        [COORD_WIDTH-2:0] cell_length_q;

	logic signed [COORD_WIDTH-1:0] coord [qni_pkg::LANES];
	logic                          off_valid;
	logic        [COORD_WIDTH-2:0] off_pos [qni_pkg::LANES];
	logic                          div_valid;
	logic        [LEVELS-1:0]      cell_no [qni_pkg::LANES];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q    <= COORD_WIDTH'(qni_pkg::RST_ORIGIN_X);
			origin_z_q    <= COORD_WIDTH'(qni_pkg::RST_ORIGIN_Z);
			clamp_hi_q    <= (COORD_WIDTH-1)'(qni_pkg::RST_FIELD_LENGTH - 1);
			cell_length_q <= (COORD_WIDTH-1)'(qni_pkg::RST_CELL_LENGTH);
		end else if (wr_en) begin
			case (qni_pkg::reg_index_t'(wr_index))
				qni_pkg::REG_ORIGIN_X: begin
					origin_x_q <= wr_data;
				end
				qni_pkg::REG_ORIGIN_Z: begin
					origin_z_q <= wr_data;
				end
				qni_pkg::REG_FIELD_LENGTH: begin
					clamp_hi_q <= (wr_data[COORD_WIDTH-2:0] == '0) ? '0 :
						wr_data[COORD_WIDTH-2:0] - 1'b1;
				end
				qni_pkg::REG_CELL_LENGTH: begin
					cell_length_q <= wr_data[COORD_WIDTH-2:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign coord[0] = min_x;
	assign coord[1] = min_z;
	assign coord[2] = max_x;
	assign coord[3] = max_z;

	qni_offset #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_offset (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (start & ~busy),
		.coord    (coord),
		.origin_x (origin_x_q),
		.origin_z (origin_z_q),
		.clamp_hi (clamp_hi_q),
		.valid_s1 (off_valid),
		.pos_s1   (off_pos)
	);

	qni_div #(
		.COORD_WIDTH(COORD_WIDTH),
		.LEVELS     (LEVELS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (off_valid),
		.num       (off_pos),
		.den       (cell_length_q),
		.valid_out (div_valid),
		.quo       (cell_no)
	);

	qni_encode #(
		.LEVELS(LEVELS)
	) u_encode (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_in   (div_valid),
		.cell_no    (cell_no),
		.done       (done),
		.node_index (node_index),
		.tree_level (tree_level)
	);

endmodule

`default_nettype wire
